// ----- hw/rtl/tmcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants for the text-mode console writer: geometry, field widths,
// command codes and character codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmcw_pkg;

    // Screen geometry
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int SCROLL_LIMIT = (ROWS - 1) * COLUMNS;   // first cell of last row
    localparam int CLEAR_START  = (ROWS - 2) * COLUMNS;   // first cell of row cleared on scroll

    // Field widths
    localparam int MODE_W = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int MEM_AW = $clog2(CELLS);

    // Command codes
    localparam logic [MODE_W-1:0] MODE_PUT       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACKSPACE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ      = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

endpackage

// ----- hw/rtl/tmcw_cmd_if.sv -----
// ----------------------------------------------------------------------------
// tmcw_cmd_if
// Command channel: mode, character and cell address with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tmcw_cmd_if;
    import tmcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;

    modport source (output valid, output mode, output char_code, output cell_address,
                    input ready);
    modport sink   (input valid, input mode, input char_code, input cell_address,
                    output ready);
endinterface

// ----- hw/rtl/tmcw_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tmcw_rsp_if
// Response channel: cursor, read cell and scroll flag with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tmcw_rsp_if;
    import tmcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;

    modport source (output valid, output cursor_position, output cell_data,
                    output scrolled, input ready);
    modport sink   (input valid, input cursor_position, input cell_data,
                    input scrolled, output ready);
endinterface

// ----- hw/rtl/tmcw_cfg_if.sv -----
// ----------------------------------------------------------------------------
// tmcw_cfg_if
// Configuration write channel for the text attribute register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tmcw_cfg_if;
    import tmcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_attribute;

    modport source (output valid, output text_attribute, input ready);
    modport sink   (input valid, input text_attribute, output ready);
endinterface

// ----- hw/rtl/text_mode_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_mode_console_writer
// A command is taken only in idle, so a new one waits until the response
// register has loaded. Put and backspace pass through post, where a space is
// written at the new cursor (a glyph is written when the put is taken) on the
// single write port of the cell buffer; a cursor in the last row scrolls first.
// Reset: cursor 0, attribute 0x07; a clearing pass zeroes the buffer, during
// which no command is taken (configuration writes are).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_mode_console_writer (
    input  logic      clk,
    input  logic      rst_n,
    tmcw_cmd_if.sink  cmd,
    tmcw_rsp_if.source rsp,
    tmcw_cfg_if.sink  cfg
);
    import tmcw_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_POST   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // Cell buffer
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ATTR_W-1:0] attr_reg;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic [ADDR_W-1:0] pipe_idx_reg;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              in_range_reg, in_range_next;
    logic              scrolled_reg, scrolled_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_cursor_reg;
    logic [CELL_W-1:0] out_data_reg;
    logic              out_scrolled_reg;

    logic accept;
    logic out_free;
    logic load_out;
    logic need_scroll;

    assign cfg.ready = 1'b1;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign need_scroll = (cursor_reg >= ADDR_W'(SCROLL_LIMIT));

    assign rsp.valid           = out_valid_reg;
    assign rsp.cursor_position = out_cursor_reg;
    assign rsp.cell_data       = out_data_reg;
    assign rsp.scrolled        = out_scrolled_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        idx_next        = idx_reg;
        mode_next       = mode_reg;
        in_range_next   = in_range_reg;
        scrolled_next   = scrolled_reg;
        pipe_valid_next = 1'b0;
        load_out        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = MEM_AW'(cmd.cell_address);

        unique case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next     = cmd.mode;
                    scrolled_next = 1'b0;
                    in_range_next = (cmd.cell_address < ADDR_W'(CELLS));
                    if (cmd.mode == MODE_PUT)
                    begin
                        state_next = ST_POST;
                        if (cmd.char_code == NEWLINE_CODE)
                        begin
                            cursor_next = cursor_reg + ADDR_W'(COLUMNS) - ADDR_W'(col_reg);
                            col_next    = '0;
                        end
                        else
                        begin
                            cursor_next = cursor_reg + 1'b1;
                            col_next    = (col_reg == COL_W'(COLUMNS - 1)) ? '0
                                                                           : col_reg + 1'b1;
                        end
                    end
                    else if (cmd.mode == MODE_BACKSPACE)
                    begin
                        state_next = ST_POST;
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - 1'b1;
                            col_next    = (col_reg == '0) ? COL_W'(COLUMNS - 1)
                                                          : col_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                        rd_en      = (cmd.mode == MODE_READ) &&
                                     (cmd.cell_address < ADDR_W'(CELLS));
                    end
                end
            end
            ST_POST:
            begin
                if (need_scroll)
                begin
                    // cursor sits at the start of the last row here
                    scrolled_next = 1'b1;
                    cursor_next   = cursor_reg - ADDR_W'(COLUMNS);
                    idx_next      = '0;
                    state_next    = ST_SCROLL;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCROLL:
            begin
                // read row below, written in the next cycle by the pipe stage
                rd_en           = (idx_reg < ADDR_W'(CLEAR_START));
                rd_addr         = MEM_AW'(idx_reg + ADDR_W'(COLUMNS));
                pipe_valid_next = 1'b1;
                idx_next        = idx_reg + 1'b1;
                if (idx_reg == ADDR_W'(SCROLL_LIMIT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_POST;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Single write port arbitration
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = MEM_AW'(cursor_reg);
        wr_data = {attr_reg, SPACE_CODE};
        priority if (pipe_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = MEM_AW'(pipe_idx_reg);
            wr_data = (pipe_idx_reg < ADDR_W'(CLEAR_START)) ? rdata_reg : '0;
        end
        else if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = MEM_AW'(idx_reg);
            wr_data = '0;
        end
        else if (accept && cmd.mode == MODE_PUT && cmd.char_code != NEWLINE_CODE)
        begin
            wr_en   = 1'b1;
            wr_data = {attr_reg, cmd.char_code};
        end
        else if (state_reg == ST_POST && !need_scroll)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= idx_reg;
        if (load_out)
        begin
            out_cursor_reg   <= cursor_reg;
            out_data_reg     <= (mode_reg == MODE_READ && in_range_reg) ? rdata_reg : '0;
            out_scrolled_reg <= scrolled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cursor_reg     <= '0;
            col_reg        <= '0;
            attr_reg       <= ATTR_RESET;
            idx_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            mode_reg       <= MODE_PUT;
            in_range_reg   <= 1'b0;
            scrolled_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            idx_reg        <= idx_next;
            pipe_valid_reg <= pipe_valid_next;
            mode_reg       <= mode_next;
            in_range_reg   <= in_range_next;
            scrolled_reg   <= scrolled_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                attr_reg <= cfg.text_attribute;
            end
        end
    end

`ifndef SYNTHESIS
    // Between items the cursor never rests in the last row
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> cursor_reg < ADDR_W'(SCROLL_LIMIT))
        else $error("cursor in last row while idle");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(COLUMNS))
        else $error("column out of range");

    // Scroll pipe owns the write port only during the sweep and drain
    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> (state_reg == ST_SCROLL || state_reg == ST_DRAIN))
        else $error("scroll write outside sweep");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.scrolled |-> rsp.cursor_position == ADDR_W'(CLEAR_START))
        else $error("cursor wrong after scroll");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("response overwritten");
`endif

endmodule

// ----- test/text_mode_console_writer_tb.sv -----
// ----------------------------------------------------------------------------
// text_mode_console_writer_tb
// Drives put, backspace, read and unused commands into the console writer,
// keeps its own copy of the screen, cursor and attribute, and compares every
// response field by field. The stimulus covers directed corner cases and
// random sessions of lines, backspaces and reads under several attributes.
// Both handshake sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_mode_console_writer_tb;
    import tmcw_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_ADDR = (1 << ADDR_W) - 1;
    // every command scrolling with the longest gap and stall, plus the clearing pass
    localparam int CYCLE_LIMIT = 8_000_000;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor_position;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } console_reply_t;

    logic clk;
    logic rst_n;

    tmcw_cmd_if cmd_bus ();
    tmcw_rsp_if rsp_bus ();
    tmcw_cfg_if cfg_bus ();

    text_mode_console_writer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // Screen model
    logic [CELL_W-1:0] screen_model [0:CELLS-1];
    int                cursor_model;
    logic [ATTR_W-1:0] attribute_model;
    console_reply_t    pending_replies [$];

    int  mismatch_count;
    int  cycle_count;
    bit  quiet_tail;
    int  stall_left;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Response side: random stall bursts
    initial
    begin
        rsp_bus.ready = 1'b1;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (quiet_tail)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what, input console_reply_t want,
                                   input console_reply_t got);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
            $display({"mismatch (%s) at %0t: want cursor=%0d cell=%h scrolled=%0b,",
                      " got cursor=%0d cell=%h scrolled=%0b"},
                     what, $realtime, want.cursor_position, want.cell_data, want.scrolled,
                     got.cursor_position, got.cell_data, got.scrolled);
    endtask

    // Check each response transaction against the oldest prediction
    always @(posedge clk)
    begin : reply_check
        console_reply_t want;
        console_reply_t got;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.cursor_position = rsp_bus.cursor_position;
            got.cell_data       = rsp_bus.cell_data;
            got.scrolled        = rsp_bus.scrolled;
            if (pending_replies.size() == 0)
            begin
                want = '0;
                report_mismatch("unexpected response", want, got);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.cursor_position !== want.cursor_position)
                    report_mismatch("cursor_position", want, got);
                else if (got.cell_data !== want.cell_data)
                    report_mismatch("cell_data", want, got);
                else if (got.scrolled !== want.scrolled)
                    report_mismatch("scrolled", want, got);
            end
        end
    end

    task automatic predict_and_queue(input logic [MODE_W-1:0] mode,
                                     input logic [CHAR_W-1:0] char_code,
                                     input logic [ADDR_W-1:0] cell_address);
        console_reply_t reply;
        reply = '0;
        if (mode == MODE_PUT || mode == MODE_BACKSPACE)
        begin
            if (cursor_model >= SCROLL_LIMIT)
                cursor_model = 0;
            if (mode == MODE_BACKSPACE)
            begin
                if (cursor_model > 0)
                    cursor_model = cursor_model - 1;
            end
            else if (char_code == NEWLINE_CODE)
            begin
                cursor_model = cursor_model + COLUMNS - (cursor_model % COLUMNS);
            end
            else
            begin
                screen_model[cursor_model] = {attribute_model, char_code};
                cursor_model = cursor_model + 1;
            end
            // landing on the last row shifts rows 1..ROWS-2 up one
            if (cursor_model >= SCROLL_LIMIT)
            begin
                for (int i = 0; i < CLEAR_START; i++)
                    screen_model[i] = screen_model[i + COLUMNS];
                cursor_model = cursor_model - COLUMNS;
                for (int i = cursor_model; i < SCROLL_LIMIT; i++)
                    screen_model[i] = '0;
                reply.scrolled = 1'b1;
            end
            screen_model[cursor_model] = {attribute_model, SPACE_CODE};
        end
        else if (mode == MODE_READ && cell_address < CELLS)
        begin
            reply.cell_data = screen_model[cell_address];
        end
        reply.cursor_position = cursor_model[ADDR_W-1:0];
        pending_replies.push_back(reply);
    endtask

    // Leaves valid high on return; the next call may lower it, an idle step does
    task automatic send_command(input logic [MODE_W-1:0] mode,
                                input logic [CHAR_W-1:0] char_code,
                                input logic [ADDR_W-1:0] cell_address);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.mode         <= mode;
        cmd_bus.char_code    <= char_code;
        cmd_bus.cell_address <= cell_address;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        predict_and_queue(mode, char_code, cell_address);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cmd_bus.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.text_attribute <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid   <= 1'b0;
        attribute_model = value;
    endtask

    function automatic logic [ADDR_W-1:0] pick_read_address();
        int pick;
        int addr;
        pick = $urandom_range(0, 19);
        if (pick < 8)
        begin
            addr = cursor_model - 90 + int'($urandom_range(0, 180));
            if (addr < 0)
                addr = 0;
            if (addr > CELLS - 1)
                addr = CELLS - 1;
        end
        else if (pick < 16)
            addr = $urandom_range(0, CELLS - 1);
        else if (pick < 18)
            addr = $urandom_range(CLEAR_START - COLUMNS, CELLS - 1);
        else
            addr = $urandom_range(CELLS, MAX_ADDR);
        return addr[ADDR_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'($urandom_range(0, MAX_ADDR));
    endfunction

    task automatic test_edge_cases();
        send_command(MODE_BACKSPACE, 8'h00, '0);        // backspace at zero
        send_command(MODE_READ, 8'h00, 11'd0);
        send_command(MODE_PUT, 8'h00, '0);
        send_command(MODE_PUT, 8'hff, '1);
        send_command(MODE_PUT, 8'h08, '0);              // backspace code is a glyph
        send_command(MODE_PUT, 8'h41, '0);
        send_command(MODE_PUT, NEWLINE_CODE, '0);
        send_command(MODE_BACKSPACE, 8'hff, '1);        // back across a row start
        send_command(MODE_UNUSED, 8'hff, '1);
        send_command(MODE_UNUSED, 8'h00, '0);
        send_command(MODE_READ, 8'h00, 11'd1);
        send_command(MODE_READ, 8'h00, 11'd2);
        send_command(MODE_READ, 8'h00, 11'd4);
        send_command(MODE_READ, 8'h00, 11'd79);
        send_command(MODE_READ, 8'h00, 11'd80);
        send_command(MODE_READ, 8'h00, ADDR_W'(CELLS - 1));
        send_command(MODE_READ, 8'hff, ADDR_W'(CELLS));  // out of range reads as zero
        send_command(MODE_READ, 8'hff, ADDR_W'(MAX_ADDR));
    endtask

    // Lines of text, backspace runs, reads and some noise
    task automatic test_console_session(input logic [ATTR_W-1:0] attribute,
                                        input int item_count);
        int sent;
        int kind;
        int run;
        write_attribute(attribute);
        sent = 0;
        while (sent < item_count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 4)
            begin
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 100)
                                                  : $urandom_range(0, 8);
                repeat (run)
                    send_command(MODE_PUT, rand_char(), rand_addr());
                sent = sent + run;
                if ($urandom_range(0, 5) != 0)
                begin
                    send_command(MODE_PUT, NEWLINE_CODE, rand_addr());
                    sent = sent + 1;
                end
            end
            else if (kind <= 6)
            begin
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 5);
                repeat (run)
                    send_command(MODE_BACKSPACE, rand_char(), rand_addr());
                sent = sent + run;
            end
            else if (kind <= 8)
            begin
                run = $urandom_range(1, 4);
                repeat (run)
                    send_command(MODE_READ, rand_char(), pick_read_address());
                sent = sent + run;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                send_command(MODE_UNUSED, rand_char(), rand_addr());
                sent = sent + 1;
            end
            else
            begin
                send_command(MODE_W'($urandom_range(0, 2)), rand_char(), rand_addr());
                sent = sent + 1;
            end
        end
    endtask

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.mode           = MODE_PUT;
        cmd_bus.char_code      = '0;
        cmd_bus.cell_address   = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.text_attribute = ATTR_RESET;
        quiet_tail             = 1'b0;
        mismatch_count         = 0;
        cycle_count            = 0;
        cursor_model           = 0;
        attribute_model        = ATTR_RESET;
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_edge_cases();
        test_console_session(8'h00, 200);
        test_console_session(8'hff, 150);
        test_console_session(ATTR_W'($urandom_range(1, 254)), 120);
        quiet_tail = 1'b1;
        test_console_session(ATTR_W'($urandom_range(0, 255)), 80);

        cmd_bus.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/tmcw_pkg.sv
hw/rtl/tmcw_cmd_if.sv
hw/rtl/tmcw_rsp_if.sv
hw/rtl/tmcw_cfg_if.sv
hw/rtl/text_mode_console_writer.sv
test/text_mode_console_writer_tb.sv
